>>> hdl/sigma_delta_motion_detect_unit_defines.svh
// Assertion helpers shared by the motion detect modules.
// Each macro expects the module to have clk and rst_n in scope.
`ifndef SIGMA_DELTA_MOTION_DETECT_UNIT_DEFINES_SVH
`define SIGMA_DELTA_MOTION_DETECT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SDMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SDMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sdmd_pkg.sv
`timescale 1ns / 1ps

package sdmd_pkg;

  localparam int PIXEL_COUNT_DEF = 65536;

  localparam int PIX_W      = 8;
  localparam int ADDR_IN_W  = 16;
  localparam int GAIN_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_MAX = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST    = 4'd3;
  localparam logic [PIX_W-1:0]  DEV_MIN_RST = 8'd1;
  localparam logic [PIX_W-1:0]  DEV_MAX_RST = 8'd254;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [PIX_W-1:0]  dev_min;
    logic [PIX_W-1:0]  dev_max;
  } cfg_t;

  // Per-stage control and pixel that travel with the address.
  typedef struct packed {
    logic             valid;
    logic             init;
    logic [PIX_W-1:0] pixel;
  } tag_t;

  // One entry of the state memory.
  typedef struct packed {
    logic [PIX_W-1:0] bg;
    logic [PIX_W-1:0] dev;
  } entry_t;

  typedef struct packed {
    logic             label;
    logic [PIX_W-1:0] difference;
    logic [PIX_W-1:0] background;
    logic [PIX_W-1:0] deviation;
  } res_t;

endpackage

>>> hdl/sdmd_if.sv
`timescale 1ns / 1ps

interface sdmd_in_if;
  logic                           valid;
  logic                           ready;
  logic [sdmd_pkg::PIX_W-1:0]     pixel;
  logic [sdmd_pkg::ADDR_IN_W-1:0] pixel_address;
  logic                           init;

  modport source (output valid, pixel, pixel_address, init, input ready);
  modport sink (input valid, pixel, pixel_address, init, output ready);
endinterface

interface sdmd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       label;
  logic [sdmd_pkg::PIX_W-1:0] difference;
  logic [sdmd_pkg::PIX_W-1:0] background_out;
  logic [sdmd_pkg::PIX_W-1:0] deviation_out;

  modport source (output valid, label, difference, background_out, deviation_out,
                  input ready);
  modport sink (input valid, label, difference, background_out, deviation_out,
                output ready);
endinterface

>>> hdl/sigma_delta_motion_detect_unit.sv
// Sigma-delta motion detector: one pixel word in, one result word out.
// Each pixel word passes through the address stages, the update stage and the output register.
// Throughput: one word per cycle while the sink keeps up, set by the state memory's one read and one write port.
// Reset clears all pipeline valid bits and loads gain 3, min 1, max 254.
// The state memory is not cleared; an entry is defined once an init word writes it.
`timescale 1ns / 1ps
`include "sigma_delta_motion_detect_unit_defines.svh"

module sigma_delta_motion_detect_unit #(
  parameter int PIXEL_COUNT = sdmd_pkg::PIXEL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sdmd_in_if.sink                         in_bus,
  sdmd_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [sdmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdmd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  // The whole pipeline advances together. It moves whenever the output
  // register is empty or its word is being taken, so a new pixel word is
  // accepted every cycle while the sink keeps up.
  logic             en;
  logic             out_valid;
  sdmd_pkg::cfg_t   cfg_r;
  sdmd_pkg::tag_t   s3_tag;
  logic [AW-1:0]    s3_addr;
  sdmd_pkg::entry_t cur;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  sdmd_pkg::entry_t wr_data;
  sdmd_pkg::res_t   res;

  assign en           = !out_valid || out_bus.ready;
  assign in_bus.ready = en;

  // Configuration registers. Writes must come only while the block is idle; it is not checked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{gain: sdmd_pkg::GAIN_RST, dev_min: sdmd_pkg::DEV_MIN_RST,
                 dev_max: sdmd_pkg::DEV_MAX_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdmd_pkg::CFG_GAIN:    cfg_r.gain    <= cfg_data[sdmd_pkg::GAIN_W-1:0];
        sdmd_pkg::CFG_DEV_MIN: cfg_r.dev_min <= cfg_data[sdmd_pkg::PIX_W-1:0];
        sdmd_pkg::CFG_DEV_MAX: cfg_r.dev_max <= cfg_data[sdmd_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Three stages of address reduction; the last one drives the memory read.
  sdmd_addr #(.PIXEL_COUNT(PIXEL_COUNT)) u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_bus.valid),
    .in_init  (in_bus.init),
    .in_pixel (in_bus.pixel),
    .in_addr  (in_bus.pixel_address),
    .tag      (s3_tag),
    .addr     (s3_addr)
  );

  // The memory's read data arrives together with the word in the update
  // stage. Only a word directly ahead can still be writing the same entry,
  // and the store forwards that write.
  sdmd_store #(.PIXEL_COUNT(PIXEL_COUNT)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .rd_addr (s3_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .cur     (cur)
  );

  // Read-modify-write of one entry, and the output register.
  sdmd_update #(.PIXEL_COUNT(PIXEL_COUNT)) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .s3_tag    (s3_tag),
    .s3_addr   (s3_addr),
    .cur       (cur),
    .cfg       (cfg_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_bus.valid          = out_valid;
  assign out_bus.label          = res.label;
  assign out_bus.difference     = res.difference;
  assign out_bus.background_out = res.background;
  assign out_bus.deviation_out  = res.deviation;

  // A motion label always means the difference reached the deviation.
  `SDMD_ASSERT_IMP(a_label, (out_bus.valid && out_bus.label), (out_bus.difference >= out_bus.deviation_out), "label without difference")

endmodule

>>> hdl/sdmd_addr.sv
`timescale 1ns / 1ps
`include "sigma_delta_motion_detect_unit_defines.svh"

// Reduces the incoming address modulo PIXEL_COUNT in three stages:
// multiply by a reciprocal, multiply back, then subtract and correct once.
module sdmd_addr #(
  parameter int PIXEL_COUNT = sdmd_pkg::PIXEL_COUNT_DEF,
  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic                           in_init,
  input  logic [sdmd_pkg::PIX_W-1:0]     in_pixel,
  input  logic [sdmd_pkg::ADDR_IN_W-1:0] in_addr,
  output sdmd_pkg::tag_t                 tag,
  output logic [AW-1:0]                  addr
);

  localparam int PW = $clog2(PIXEL_COUNT + 1);
  localparam int RW = (PW > 17) ? PW : 17;
  localparam logic [32:0]   RECIP = 33'((64'd1 << 32) / PIXEL_COUNT);
  localparam logic [RW-1:0] P_R   = RW'(PIXEL_COUNT);

  sdmd_pkg::tag_t s1_tag_r, s2_tag_r, s3_tag_r;
  logic [15:0]    s1_a_r, s2_a_r;
  logic [48:0]    s1_prod_r;
  logic [48:0]    prod_nxt;
  logic [16:0]    quot;
  logic [RW+16:0] qp_full;
  logic [16:0]    s2_qp_r;
  logic [RW-1:0]  r_est, r_fix;
  logic [AW-1:0]  s3_addr_r;

  // The quotient estimate is low by at most one, so the remainder is below 2*PIXEL_COUNT.
  assign prod_nxt = 49'(in_addr) * 49'(RECIP);
  assign quot     = s1_prod_r[48:32];
  assign qp_full  = (RW + 17)'(quot) * (RW + 17)'(P_R);
  assign r_est    = RW'(s2_a_r) - RW'(s2_qp_r);
  assign r_fix    = (r_est >= P_R) ? (r_est - P_R) : r_est;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
      s2_tag_r.valid <= 1'b0;
      s3_tag_r.valid <= 1'b0;
    end else if (en) begin
      s1_tag_r  <= '{valid: in_valid, init: in_init, pixel: in_pixel};
      s1_a_r    <= in_addr;
      s1_prod_r <= prod_nxt;
      s2_tag_r  <= s1_tag_r;
      s2_a_r    <= s1_a_r;
      s2_qp_r   <= qp_full[16:0];
      s3_tag_r  <= s2_tag_r;
      s3_addr_r <= AW'(r_fix);
    end
  end

  assign tag  = s3_tag_r;
  assign addr = s3_addr_r;

  `SDMD_ASSERT_IMP(a_addr_range, s3_tag_r.valid, (RW'(s3_addr_r) < P_R), "address not reduced")

endmodule

>>> hdl/sdmd_store.sv
`timescale 1ns / 1ps
`include "sigma_delta_motion_detect_unit_defines.svh"

// State memory holding background and deviation per pixel. One read and one write
// per enabled cycle; a write to the entry read in the same cycle is forwarded.
module sdmd_store #(
  parameter int PIXEL_COUNT = sdmd_pkg::PIXEL_COUNT_DEF,
  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [AW-1:0]       rd_addr,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  sdmd_pkg::entry_t    wr_data,
  output sdmd_pkg::entry_t    cur
);

  sdmd_pkg::entry_t mem [PIXEL_COUNT];
  sdmd_pkg::entry_t rd_r;
  sdmd_pkg::entry_t fwd_data_r;
  logic             fwd_hit_r;

  always_ff @(posedge clk) begin
    if (en && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r       <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign cur = fwd_hit_r ? fwd_data_r : rd_r;

  `SDMD_ASSERT_NEXT(a_fwd, (en && wr_en && (wr_addr == rd_addr)), (cur == $past(wr_data)), "forward lost")

endmodule

>>> hdl/sdmd_update.sv
`timescale 1ns / 1ps

// Update stage: steps background and deviation, or loads them for an init word,
// forms the label, writes the entry back and registers the result word.
module sdmd_update #(
  parameter int PIXEL_COUNT = sdmd_pkg::PIXEL_COUNT_DEF,
  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  sdmd_pkg::tag_t   s3_tag,
  input  logic [AW-1:0]    s3_addr,
  input  sdmd_pkg::entry_t cur,
  input  sdmd_pkg::cfg_t   cfg,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output sdmd_pkg::entry_t wr_data,
  output logic             out_valid,
  output sdmd_pkg::res_t   res
);

  sdmd_pkg::tag_t s4_tag_r;
  logic [AW-1:0]  s4_addr_r;
  logic           out_valid_r;
  sdmd_pkg::res_t res_r;
  sdmd_pkg::res_t res_nxt;

  logic [7:0]  pix, bg_c, diff_c, dev_c;
  logic [11:0] target_c;
  logic [8:0]  dev_step_c;

  assign pix = s4_tag_r.pixel;

  always_comb begin
    bg_c = cur.bg;
    if (cur.bg < pix) begin
      bg_c = cur.bg + 8'd1;
    end else if (cur.bg > pix) begin
      bg_c = cur.bg - 8'd1;
    end
    diff_c   = (bg_c > pix) ? (bg_c - pix) : (pix - bg_c);
    target_c = 12'(cfg.gain) * 12'(diff_c);

    // Nine bits so that a step up from 255 does not wrap before the clamp.
    dev_step_c = 9'(cur.dev);
    if (12'(cur.dev) < target_c) begin
      dev_step_c = 9'(cur.dev) + 9'd1;
    end else if (12'(cur.dev) > target_c) begin
      dev_step_c = 9'(cur.dev) - 9'd1;
    end
    if (dev_step_c > 9'(cfg.dev_max)) begin
      dev_step_c = 9'(cfg.dev_max);
    end
    if (dev_step_c < 9'(cfg.dev_min)) begin
      dev_step_c = 9'(cfg.dev_min);
    end
    dev_c = dev_step_c[7:0];

    if (s4_tag_r.init) begin
      res_nxt = '{label: 1'b0, difference: 8'd0, background: pix, deviation: cfg.dev_min};
    end else begin
      res_nxt = '{label: (diff_c >= dev_c), difference: diff_c, background: bg_c,
                  deviation: dev_c};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_tag_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else if (en) begin
      s4_tag_r    <= s3_tag;
      s4_addr_r   <= s3_addr;
      out_valid_r <= s4_tag_r.valid;
      res_r       <= res_nxt;
    end
  end

  assign wr_en     = s4_tag_r.valid;
  assign wr_addr   = s4_addr_r;
  assign wr_data   = '{bg: res_nxt.background, dev: res_nxt.deviation};
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

>>> test/tb_sigma_delta_motion_detect_unit.sv
`timescale 1ns / 1ps

module tb_sigma_delta_motion_detect_unit;
  import sdmd_pkg::*;

  // The limit leaves a very wide margin over the length of the run.
  localparam int CYCLE_LIMIT  = 200000;
  // The settle wait after the last result word, before a register write,
  // leaves the pipeline empty.
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;
  localparam int IDLE_PERCENT  = 21;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sdmd_in_if  pix_bus ();
  sdmd_out_if res_bus ();

  sigma_delta_motion_detect_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (pix_bus),
    .out_bus  (res_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // The testbench's own copy of the register file, kept in step with every
  // write to the block.
  logic [GAIN_W-1:0] gain_q;
  logic [PIX_W-1:0]  dev_min_q;
  logic [PIX_W-1:0]  dev_max_q;

  // The per-pixel background and deviation. An address has an entry only
  // after an init word wrote it, so exists() tells which pixels may be updated.
  logic [PIX_W-1:0]     background_mem [int];
  logic [PIX_W-1:0]     deviation_mem [int];
  logic [ADDR_IN_W-1:0] live_pixels [$];

  // Result words predicted for accepted pixel words, oldest first.
  res_t pending_results [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  // When steady_flow is set, neither side idles. When hold_cycles is nonzero,
  // the receiver holds ready low and counts hold_cycles down.
  bit steady_flow = 1'b0;
  int hold_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog. A hung handshake or a lost result word ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int step_toward(input int cur, input int target);
    if (cur < target) return cur + 1;
    if (cur > target) return cur - 1;
    return cur;
  endfunction

  // Predicts the result word for one pixel word and updates the stored
  // entries of that pixel, just as the block does when it accepts the word.
  // The deviation is computed as an int, so a step up from 255 reaches 256
  // before the clamp. The upper clamp comes first, so dev_min wins when the
  // two bounds cross.
  function automatic res_t predict_motion(input logic [PIX_W-1:0]     pix,
                                          input logic [ADDR_IN_W-1:0] addr,
                                          input logic                 init_f);
    res_t r;
    int   p;
    int   bg;
    int   dev;
    int   diff;
    p = pix;
    if (init_f) begin
      bg   = p;
      dev  = dev_min_q;
      diff = 0;
    end else begin
      bg   = step_toward(background_mem[int'(addr)], p);
      diff = (bg > p) ? bg - p : p - bg;
      dev  = step_toward(deviation_mem[int'(addr)], int'(gain_q) * diff);
      if (dev > int'(dev_max_q)) dev = dev_max_q;
      if (dev < int'(dev_min_q)) dev = dev_min_q;
    end
    background_mem[int'(addr)] = PIX_W'(bg);
    deviation_mem[int'(addr)]  = PIX_W'(dev);
    r.label      = !init_f && (diff >= dev);
    r.difference = PIX_W'(diff);
    r.background = PIX_W'(bg);
    r.deviation  = PIX_W'(dev);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // Offers one pixel word. The offer starts at a falling edge, after
  // random idle cycles unless steady_flow is set. The task returns at the
  // rising edge that accepts the word. valid stays high, so the next call can
  // present its word at the following falling edge.
  task automatic send_pixel(input logic [PIX_W-1:0]     pix,
                            input logic [ADDR_IN_W-1:0] addr,
                            input logic                 init_f);
    bit fresh;
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      pix_bus.valid <= 1'b0;
      @(negedge clk);
    end
    pix_bus.valid         <= 1'b1;
    pix_bus.pixel         <= pix;
    pix_bus.pixel_address <= addr;
    pix_bus.init          <= init_f;
    do @(posedge clk); while (pix_bus.ready !== 1'b1);
    fresh = !background_mem.exists(int'(addr));
    pending_results.push_back(predict_motion(pix, addr, init_f));
    if (init_f && fresh) live_pixels.push_back(addr);
  endtask

  // Stops the input stream and waits for every predicted word to come back.
  // It then lets the pipeline settle, so that a register write that follows
  // lands on an idle block.
  task automatic wait_drained();
    @(negedge clk);
    pix_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_GAIN:    gain_q    = val[GAIN_W-1:0];
      CFG_DEV_MIN: dev_min_q = val;
      CFG_DEV_MAX: dev_max_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The gain register is 4 bits wide. Its upper data bits get random values
  // and must be ignored.
  task automatic set_config(input logic [GAIN_W-1:0] g,
                            input logic [PIX_W-1:0]  lo,
                            input logic [PIX_W-1:0]  hi);
    write_register(CFG_GAIN, {4'($urandom_range(0, 15)), g});
    write_register(CFG_DEV_MIN, lo);
    write_register(CFG_DEV_MAX, hi);
  endtask

  // Random traffic that looks like a video stream. Most words update pixels
  // that were already initialized, usually with a grey level close to the
  // current background. That exercises the slow one-step tracking of the
  // background and of the deviation. The rest is noise: random and extreme
  // levels, fresh init words anywhere in the frame, and re-inits of live
  // pixels. Addresses come mostly from the last few live pixels, so the same
  // pixel often comes back while its previous word is still in the pipeline.
  task automatic stream_pixels(input int count);
    logic [ADDR_IN_W-1:0] addr;
    int                   pix;
    int                   span;
    int                   pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (live_pixels.size() == 0 || pick < 8) begin
        if (live_pixels.size() != 0 && $urandom_range(0, 3) == 0)
          addr = live_pixels[$urandom_range(0, live_pixels.size() - 1)];
        else
          addr = ADDR_IN_W'($urandom_range(0, 65535));
        send_pixel(PIX_W'($urandom_range(0, 255)), addr, 1'b1);
      end else begin
        span = (live_pixels.size() < 8) ? live_pixels.size() : 8;
        addr = live_pixels[live_pixels.size() - 1 - $urandom_range(0, span - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          pix = int'(background_mem[int'(addr)]) + $urandom_range(0, 10) - 5;
          if (pix < 0) pix = 0;
          if (pix > 255) pix = 255;
        end else if (pick < 85) begin
          pix = $urandom_range(0, 255);
        end else begin
          pix = $urandom_range(0, 1) ? 255 : 0;
        end
        send_pixel(PIX_W'(pix), addr, 1'b0);
      end
    end
  endtask

  // Reset settings. The test writes init words at the lowest and highest
  // addresses and at alternating bit patterns, each followed by full-scale jumps.
  // Updates of the same pixel come back to back, so each one depends on the
  // entry that the previous word is still writing. A re-init of a live pixel
  // must override its old entries.
  task automatic test_reset_defaults();
    send_pixel(8'h00, 16'h0000, 1'b1);
    send_pixel(8'hFF, 16'hFFFF, 1'b1);
    send_pixel(8'hFF, 16'h0000, 1'b0);
    send_pixel(8'h00, 16'hFFFF, 1'b0);
    send_pixel(8'hFF, 16'h0000, 1'b0);
    send_pixel(8'hFF, 16'h0000, 1'b0);
    send_pixel(8'h00, 16'h0000, 1'b0);
    send_pixel(8'hFF, 16'hFFFF, 1'b0);
    send_pixel(8'hAA, 16'h5555, 1'b1);
    send_pixel(8'h55, 16'hAAAA, 1'b1);
    send_pixel(8'h00, 16'h5555, 1'b0);
    send_pixel(8'hFF, 16'hAAAA, 1'b0);
    send_pixel(8'h80, 16'h0000, 1'b1);
    send_pixel(8'h80, 16'h0000, 1'b0);
  endtask

  // Both bounds are at 255. An init word loads 255, and a large difference
  // pushes the deviation one step past 255. The clamp must hold it at the top
  // instead of letting the byte wrap.
  task automatic test_deviation_ceiling();
    wait_drained();
    set_config(4'd15, 8'd255, 8'd255);
    send_pixel(8'h00, 16'h1234, 1'b1);
    send_pixel(8'hFF, 16'h1234, 1'b0);
    send_pixel(8'hFF, 16'h1234, 1'b0);
  endtask

  // The lower bound sits above the upper one, so the result is always the
  // lower bound.
  task automatic test_crossed_bounds();
    wait_drained();
    set_config(4'd1, 8'd200, 8'd10);
    send_pixel(8'h00, 16'h5555, 1'b0);
    send_pixel(8'hFF, 16'hAAAA, 1'b0);
    send_pixel(8'h10, 16'h1234, 1'b1);
  endtask

  // With a gain of zero, the target is zero and the deviation only decays.
  // A zero upper bound then makes every update a motion pixel.
  task automatic test_gain_zero();
    wait_drained();
    set_config(4'd0, 8'd0, 8'd255);
    send_pixel(8'h00, 16'h1234, 1'b0);
    send_pixel(8'h00, 16'h1234, 1'b0);
    wait_drained();
    set_config(4'd1, 8'd0, 8'd0);
    send_pixel(8'h40, 16'h0000, 1'b0);
    send_pixel(8'hFF, 16'hFFFF, 1'b0);
  endtask

  task automatic test_random_traffic(input logic [GAIN_W-1:0] g,
                                     input logic [PIX_W-1:0]  lo,
                                     input logic [PIX_W-1:0]  hi,
                                     input int                count);
    wait_drained();
    set_config(g, lo, hi);
    stream_pixels(count);
  endtask

  // Neither side idles for a whole phase, so the block runs at one word
  // per cycle.
  task automatic test_steady_stream();
    wait_drained();
    set_config(4'd1, 8'd0, 8'd255);
    steady_flow = 1'b1;
    stream_pixels(75);
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words. The pipeline fills and must stall its input without
  // dropping or duplicating a word.
  task automatic test_receiver_holdoff();
    wait_drained();
    set_config(4'd15, 8'd0, 8'd40);
    hold_cycles = 150;
    stream_pixels(75);
  endtask

  // Receiver. It drives ready at each falling edge: low during a hold-off,
  // always high in steady flow, and otherwise randomly low IDLE_PERCENT percent of the time.
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (steady_flow) begin
        res_bus.ready <= 1'b1;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Checker. Each result word accepted at a rising edge is compared, field by
  // field, with the oldest prediction.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result word: label %0b diff %0d bg %0d dev %0d",
                             res_bus.label, res_bus.difference,
                             res_bus.background_out, res_bus.deviation_out));
      end else begin
        want = pending_results.pop_front();
        if (res_bus.label !== want.label || res_bus.difference !== want.difference ||
            res_bus.background_out !== want.background ||
            res_bus.deviation_out !== want.deviation)
          flag_error($sformatf({"result mismatch: expected label %0b diff %0d bg %0d dev %0d,",
                                " got label %0b diff %0d bg %0d dev %0d"},
                               want.label, want.difference, want.background,
                               want.deviation, res_bus.label, res_bus.difference,
                               res_bus.background_out, res_bus.deviation_out));
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_GAIN;
    cfg_data              = '0;
    pix_bus.valid         = 1'b0;
    pix_bus.pixel         = '0;
    pix_bus.pixel_address = '0;
    pix_bus.init          = 1'b0;
    gain_q                = GAIN_RST;
    dev_min_q             = DEV_MIN_RST;
    dev_max_q             = DEV_MAX_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_deviation_ceiling();
    test_crossed_bounds();
    test_gain_zero();
    test_random_traffic(GAIN_RST, DEV_MIN_RST, DEV_MAX_RST, 75);
    test_steady_stream();
    test_receiver_holdoff();
    test_random_traffic(4'd8, 8'd5, 8'd60, 75);
    test_random_traffic(4'($urandom_range(0, 15)), 8'($urandom_range(0, 20)),
                        8'($urandom_range(100, 255)), 75);
    test_random_traffic(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 75);

    wait_drained();
    if (pending_results.size() != 0) flag_error("result words missing at end of run");
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
